// ===== hdl/aenc_pkg.sv =====
package aenc_pkg;

  // Defaults for the top-level parameters.
  localparam int ALPHABET_SIZE_DEF = 5;
  localparam int PENDING_MAX_DEF   = 256;

  // Fixed field geometry.
  localparam int FREQ_FIELDS = 5;
  localparam int FREQ_W      = 32;
  localparam int SYM_W       = 3;
  localparam int IVAL_W      = 63;
  localparam int IN_DATA_W   = 168;
  localparam int OUT_DATA_W  = 16;

  // Interval landmarks.
  localparam logic [IVAL_W-1:0] HALF_POINT = 63'h4000_0000_0000_0000;
  localparam logic [IVAL_W-1:0] QUARTER    = 63'h2000_0000_0000_0000;
  localparam logic [34:0]       TOTAL_FREQ = 35'h0_8000_0000;

  // Result status codes.
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_BAD_SYM   = 3'd1;
  localparam logic [2:0] ST_ZERO_FREQ = 3'd2;
  localparam logic [2:0] ST_BAD_TOTAL = 3'd3;
  localparam logic [2:0] ST_EMPTY     = 3'd4;
  localparam logic [2:0] ST_FINISHED  = 3'd5;
  localparam logic [2:0] ST_PEND_OVF  = 3'd6;

  typedef enum logic [3:0] {
    S_IDLE, S_CHECK, S_MUL, S_NARROW, S_PASS1, S_COMMIT, S_FIN,
    S_PASS2, S_EMIT, S_PAD, S_END, S_ERR
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic check;
    logic mul;
    logic narrow;
    logic pass1;
    logic commit;
    logic fin;
    logic pass2;
    logic emit;
    logic pad;
    logic done_item;
    logic err;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic chk_err;
    logic is_fin;
    logic mul_last;
    logic nar_bad;
    logic p1_stop;
    logic p1_ovf;
    logic p2_stop;
    logic p2_emit;
    logic emit_done;
    logic pad_go;
    logic end_go;
    logic err_go;
  } stat_t;

endpackage

// ===== hdl/aenc_ctrl.sv =====
module aenc_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_fire,
  input  aenc_pkg::stat_t st,
  output aenc_pkg::cmd_t  cmd,
  output logic           in_ready
);
  import aenc_pkg::*;

  state_t state, state_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:   if (in_fire) state_next = S_CHECK;
      S_CHECK: begin
        if (st.chk_err)     state_next = S_ERR;
        else if (st.is_fin) state_next = S_FIN;
        else                state_next = S_MUL;
      end
      S_MUL:    if (st.mul_last) state_next = S_NARROW;
      S_NARROW: state_next = st.nar_bad ? S_ERR : S_PASS1;
      S_PASS1: begin
        if (st.p1_ovf)       state_next = S_ERR;
        else if (st.p1_stop) state_next = S_COMMIT;
      end
      S_COMMIT: state_next = S_PASS2;
      S_FIN:    state_next = S_EMIT;
      S_PASS2: begin
        if (st.p2_stop)      state_next = S_END;
        else if (st.p2_emit) state_next = S_EMIT;
      end
      S_EMIT:   if (st.emit_done) state_next = st.is_fin ? S_PAD : S_PASS2;
      S_PAD:    if (st.pad_go) state_next = S_END;
      S_END:    if (st.end_go) state_next = S_IDLE;
      S_ERR:    if (st.err_go) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  // Command outputs.
  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        cmd.load = 1'b1;
      end
      S_CHECK:  cmd.check     = 1'b1;
      S_MUL:    cmd.mul       = 1'b1;
      S_NARROW: cmd.narrow    = 1'b1;
      S_PASS1:  cmd.pass1     = 1'b1;
      S_COMMIT: cmd.commit    = 1'b1;
      S_FIN:    cmd.fin       = 1'b1;
      S_PASS2:  cmd.pass2     = 1'b1;
      S_EMIT:   cmd.emit      = 1'b1;
      S_PAD:    cmd.pad       = 1'b1;
      S_END:    cmd.done_item = 1'b1;
      S_ERR:    cmd.err       = 1'b1;
      default:  cmd           = '0;
    endcase
  end

endmodule

// ===== hdl/aenc_dp.sv =====
module aenc_dp #(
  parameter int ALPHABET_SIZE = aenc_pkg::ALPHABET_SIZE_DEF,
  parameter int PENDING_MAX   = aenc_pkg::PENDING_MAX_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  aenc_pkg::cmd_t                   cmd,
  input  logic                             in_fire,
  input  logic                             in_op,
  input  logic [aenc_pkg::IN_DATA_W-1:0]   in_data,
  output aenc_pkg::stat_t                  st,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [aenc_pkg::OUT_DATA_W-1:0]  out_data,
  output logic                             out_flag,
  output logic                             out_last
);
  import aenc_pkg::*;

  localparam int PW  = $clog2(PENDING_MAX + 2);
  localparam int NBW = $clog2(PENDING_MAX + 140) + 1;

  // Architectural coder state.
  logic [IVAL_W-1:0] low, high;
  logic [PW-1:0]     pending;
  logic [7:0]        part;
  logic [2:0]        part_n;
  logic              done;

  // Latched input item.
  logic              op_r;
  logic [SYM_W-1:0]  sym_r;
  logic [FREQ_W-1:0] freq_r [FREQ_FIELDS];

  // Working registers.
  logic [2:0]        err_r;
  logic [FREQ_W-1:0] cum_lo, cum_hi;
  logic [63:0]       width_r, prod, lo_off, hi_off;
  logic [2:0]        mcnt;
  logic [IVAL_W-1:0] nlow, nhigh, wlow, whigh;
  logic [PW-1:0]     wpend;
  logic [NBW-1:0]    nbits, bytes_left;
  logic [7:0]        guard;
  logic              ebit, first, any_byte;

  // Output register.
  logic [7:0] o_byte;
  logic [2:0] o_status;
  logic       out_free;
  assign out_free = !out_valid || out_ready;
  assign out_data = {5'd0, o_status, o_byte};

  // Frequency validation and cumulative sums.
  logic [FREQ_W-1:0] fext [8];
  logic [34:0]       total;
  logic [FREQ_W:0]   cl_sum, f_sym;
  logic              zero_f, sym_bad;
  logic [2:0]        chk_code;
  always_comb begin
    for (int i = 0; i < 8; i++) begin
      fext[i] = '0;
    end
    for (int i = 0; i < FREQ_FIELDS; i++) begin
      fext[i] = freq_r[i];
    end
    total  = '0;
    cl_sum = '0;
    f_sym  = '0;
    zero_f = 1'b0;
    for (int i = 0; i < ALPHABET_SIZE; i++) begin
      if (fext[i] == '0) zero_f = 1'b1;
      total = total + 35'(fext[i]);
      if (4'(i) < {1'b0, sym_r}) cl_sum = cl_sum + 33'(fext[i]);
      if (4'(i) == {1'b0, sym_r}) f_sym = 33'(fext[i]);
    end
    sym_bad = {1'b0, sym_r} >= 4'(ALPHABET_SIZE);
    if (done)                    chk_code = ST_FINISHED;
    else if (op_r)               chk_code = ST_OK;
    else if (sym_bad)            chk_code = ST_BAD_SYM;
    else if (zero_f)             chk_code = ST_ZERO_FREQ;
    else if (total != TOTAL_FREQ) chk_code = ST_BAD_TOTAL;
    else                         chk_code = ST_OK;
  end

  // Multiplier operand selection: wh*cl, wl*cl, wh*ch, wl*ch.
  logic [31:0] mul_a, mul_b;
  assign mul_a = mcnt[0] ? width_r[31:0] : width_r[63:32];
  assign mul_b = mcnt[1] ? cum_hi : cum_lo;

  // Renormalization decisions on the working and the committed interval.
  logic w_lt, w_ge, w_uf, w_stop, c_lt, c_ge, c_uf, c_stop;
  assign w_lt   = !whigh[62];
  assign w_ge   = wlow[62];
  assign w_uf   = wlow[61] && !whigh[61];
  assign w_stop = guard[7] || !(w_lt || w_ge || w_uf);
  assign c_lt   = !high[62];
  assign c_ge   = low[62];
  assign c_uf   = low[61] && !high[61];
  assign c_stop = guard[7] || !(c_lt || c_ge || c_uf);

  // Bit emission.
  logic e_bit, e_complete, e_adv;
  logic [7:0] e_part;
  assign e_bit      = first ? ebit : !ebit;
  assign e_complete = (part_n == 3'd7);
  assign e_adv      = !e_complete || out_free;
  assign e_part     = {part[6:0], e_bit};

  logic [7:0] pad_byte;
  assign pad_byte = part << (4'd8 - {1'b0, part_n});

  // Status toward the controller.
  always_comb begin
    st           = '0;
    st.chk_err   = (chk_code != ST_OK);
    st.is_fin    = op_r;
    st.mul_last  = (mcnt == 3'd4);
    st.nar_bad   = (hi_off <= lo_off);
    st.p1_stop   = w_stop;
    st.p1_ovf    = !w_stop && !w_lt && !w_ge && (32'(wpend) >= 32'(PENDING_MAX));
    st.p2_stop   = c_stop;
    st.p2_emit   = !c_stop && (c_lt || c_ge);
    st.emit_done = e_adv && (first ? (pending == '0) : (pending == PW'(1)));
    st.pad_go    = (part_n == 3'd0) || out_free;
    st.end_go    = any_byte || out_free;
    st.err_go    = out_free;
  end

  // Payload registers of the datapath.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      op_r  <= in_op;
      sym_r <= in_data[SYM_W-1:0];
      for (int i = 0; i < FREQ_FIELDS; i++) begin
        freq_r[i] <= in_data[SYM_W + FREQ_W*i +: FREQ_W];
      end
    end
    if (cmd.check) begin
      err_r   <= chk_code;
      cum_lo  <= cl_sum[FREQ_W-1:0];
      cum_hi  <= 32'(cl_sum + f_sym);
      width_r <= {1'b0, high} - {1'b0, low} + 64'd1;
      mcnt    <= '0;
    end
    // One 32x32 product a cycle; each is folded in the cycle after.
    if (cmd.mul) begin
      prod <= 64'(mul_a) * 64'(mul_b);
      mcnt <= mcnt + 3'd1;
      case (mcnt)
        3'd1:    lo_off <= {prod[62:0], 1'b0};
        3'd2:    lo_off <= lo_off + (prod >> 31);
        3'd3:    hi_off <= {prod[62:0], 1'b0};
        3'd4:    hi_off <= hi_off + (prod >> 31);
        default: prod   <= 64'(mul_a) * 64'(mul_b);
      endcase
    end
    // Narrow the interval into the working copy.
    if (cmd.narrow) begin
      if (hi_off <= lo_off) err_r <= ST_EMPTY;
      nlow  <= low + lo_off[IVAL_W-1:0];
      nhigh <= low + hi_off[IVAL_W-1:0] - 63'd1;
      wlow  <= low + lo_off[IVAL_W-1:0];
      whigh <= low + hi_off[IVAL_W-1:0] - 63'd1;
      wpend <= pending;
      nbits <= '0;
      guard <= '0;
    end
    // Dry run of renormalization: counts bits and catches pending overflow.
    if (cmd.pass1 && !w_stop) begin
      if (w_lt || w_ge) begin
        nbits <= nbits + NBW'(wpend) + NBW'(1);
        wpend <= '0;
        if (w_lt) begin
          wlow  <= {wlow[61:0], 1'b0};
          whigh <= {whigh[61:0], 1'b1};
        end else begin
          wlow  <= {wlow[61:0] & ~HALF_POINT[61:0], 1'b0};
          whigh <= {whigh[61:0], 1'b1};
        end
        guard <= guard + 8'd1;
      end else if (32'(wpend) >= 32'(PENDING_MAX)) begin
        err_r <= ST_PEND_OVF;
      end else begin
        wpend <= wpend + PW'(1);
        wlow  <= {wlow[61:0] - QUARTER[61:0], 1'b0};
        whigh <= {whigh[61:0] - QUARTER[61:0], 1'b1};
        guard <= guard + 8'd1;
      end
    end
    if (cmd.commit) begin
      bytes_left <= (NBW'(part_n) + nbits) >> 3;
      guard      <= '0;
    end
    if (cmd.fin) begin
      bytes_left <= (NBW'(part_n) + NBW'(pending) + NBW'(9)) >> 3;
      ebit       <= low[62] || low[61];
      first      <= 1'b1;
    end
    if (cmd.pass2 && !c_stop) begin
      guard <= guard + 8'd1;
      if (c_lt || c_ge) begin
        ebit  <= c_ge;
        first <= 1'b1;
      end
    end
    if (cmd.emit && e_adv && first) begin
      first <= 1'b0;
    end
    if (cmd.emit && e_adv && e_complete) begin
      bytes_left <= bytes_left - NBW'(1);
    end
  end

  // Committed coder state and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      low       <= '0;
      high      <= '1;
      pending   <= '0;
      part      <= '0;
      part_n    <= '0;
      done      <= 1'b0;
      any_byte  <= 1'b0;
      out_valid <= 1'b0;
      out_flag  <= 1'b0;
      out_last  <= 1'b0;
      o_byte    <= '0;
      o_status  <= ST_OK;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      if (cmd.check) any_byte <= 1'b0;
      if (cmd.commit) begin
        low  <= nlow;
        high <= nhigh;
      end
      if (cmd.fin) pending <= pending + PW'(1);
      // Real renormalization step; the shift does not wait for emission.
      if (cmd.pass2 && !c_stop) begin
        if (c_lt) begin
          low  <= {low[61:0], 1'b0};
          high <= {high[61:0], 1'b1};
        end else if (c_ge) begin
          low  <= {low[61:0] & ~HALF_POINT[61:0], 1'b0};
          high <= {high[61:0], 1'b1};
        end else begin
          pending <= pending + PW'(1);
          low     <= {low[61:0] - QUARTER[61:0], 1'b0};
          high    <= {high[61:0] - QUARTER[61:0], 1'b1};
        end
      end
      // One bit a cycle while a completed byte finds the output register free; a full byte becomes a transfer.
      if (cmd.emit && e_adv) begin
        if (!first) pending <= pending - PW'(1);
        part_n <= part_n + 3'd1;
        if (e_complete) begin
          part      <= '0;
          any_byte  <= 1'b1;
          out_valid <= 1'b1;
          o_byte    <= e_part;
          o_status  <= ST_OK;
          out_flag  <= 1'b1;
          out_last  <= (bytes_left == NBW'(1));
        end else begin
          part <= e_part;
        end
      end
      // Zero-pad the last partial byte of the stream.
      if (cmd.pad && ((part_n == 3'd0) || out_free)) begin
        done <= 1'b1;
        if (part_n != 3'd0) begin
          part      <= '0;
          part_n    <= '0;
          any_byte  <= 1'b1;
          out_valid <= 1'b1;
          o_byte    <= pad_byte;
          o_status  <= ST_OK;
          out_flag  <= 1'b1;
          out_last  <= 1'b1;
        end
      end
      // An item that made no byte, or that ended in an error, still gives one result.
      if ((cmd.done_item && !any_byte && out_free) || (cmd.err && out_free)) begin
        out_valid <= 1'b1;
        o_byte    <= '0;
        o_status  <= cmd.err ? err_r : ST_OK;
        out_flag  <= 1'b0;
        out_last  <= 1'b1;
      end
    end
  end

endmodule

// ===== hdl/arith_encoder_63bit_5sym_core.sv =====
// Channel  Signals                            Contents
// s_axis   s_tvalid s_tready s_tdata s_tuser  one encode or finish item
// m_axis   m_tvalid m_tready m_tdata m_tuser  one result, tlast on the item's final one
//
// After its transfer an encode item goes through setup (check, the products on one
// shared 32x32 multiplier, narrowing), then renormalization steps in a dry run and
// in the real pass, with a commit between them, then emits its bits and closes.
// Output stalls hold the emission of a completed byte until the single output
// register frees up. Reset is synchronous; no item is taken until a result
// sequence is finished.
module arith_encoder_63bit_5sym_core #(
  parameter int ALPHABET_SIZE = aenc_pkg::ALPHABET_SIZE_DEF,
  parameter int PENDING_MAX   = aenc_pkg::PENDING_MAX_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // symbol[2:0], freq_0[34:3], freq_1[66:35], freq_2[98:67], freq_3[130:99],
  // freq_4[162:131], zero fill above
  input  logic [aenc_pkg::IN_DATA_W-1:0]  s_tdata,
  // operation[0]
  input  logic                            s_tuser,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // out_byte[7:0], status[10:8], zero fill above
  output logic [aenc_pkg::OUT_DATA_W-1:0] m_tdata,
  // byte_valid[0]
  output logic                            m_tuser,
  output logic                            m_tlast
);
  import aenc_pkg::*;

  cmd_t  cmd;
  stat_t st;
  logic  in_fire;

  assign in_fire = s_tvalid && s_tready;

  aenc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_fire  (in_fire),
    .st       (st),
    .cmd      (cmd),
    .in_ready (s_tready)
  );

  aenc_dp #(
    .ALPHABET_SIZE (ALPHABET_SIZE),
    .PENDING_MAX   (PENDING_MAX)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .in_fire   (in_fire),
    .in_op     (s_tuser),
    .in_data   (s_tdata),
    .st        (st),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (m_tdata),
    .out_flag  (m_tuser),
    .out_last  (m_tlast)
  );

endmodule
